/* rtl/utf8_decoder_surrogate_join_top_assert.svh */
// assertion macros shared by the utf8 decoder checker file
`ifndef UTF8_DECODER_SURROGATE_JOIN_TOP_ASSERT_SVH
`define UTF8_DECODER_SURROGATE_JOIN_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, idle during reset
`define U8SJ_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("u8sj assertion failed");

// next-cycle implication, sampled on clk, idle during reset
`define U8SJ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("u8sj assertion failed");

`endif

/* rtl/u8sj_pkg.sv */
// shared types and constants of the utf8 / cesu-8 decoder
package u8sj_pkg;

	localparam int unsigned CP_W       = 21;
	localparam int unsigned TDATA_IN_W = 8;
	localparam int unsigned TDATA_OUT_W = 24;

	localparam logic [CP_W-1:0] CP_INVALID = 21'h00FFFD;
	localparam logic [CP_W-1:0] HIGH_SURR_LO = 21'h00D800;
	localparam logic [CP_W-1:0] HIGH_SURR_HI = 21'h00DBFF;
	localparam logic [CP_W-1:0] LOW_SURR_LO  = 21'h00DC00;
	localparam logic [CP_W-1:0] LOW_SURR_HI  = 21'h00DFFF;
	localparam logic [CP_W-1:0] SUPP_BASE    = 21'h010000;

	// lead byte tags, compared against the top bits of the byte
	localparam logic [2:0] LEAD2_TAG = 3'b110;
	localparam logic [3:0] LEAD3_TAG = 4'b1110;
	localparam logic [4:0] LEAD4_TAG = 5'b11110;

	// decoder state carried between bytes
	typedef struct packed {
		logic [1:0]      bytes_left;
		logic [CP_W-1:0] partial_value;
		logic [9:0]      held_high;
		logic            surr_pending;
	} u8sj_state_t;

	// one result of a byte step
	typedef struct packed {
		logic            emit;
		logic [CP_W-1:0] code_point;
		logic            status;
		logic            last;
	} u8sj_result_t;

endpackage

/* rtl/u8sj_decode.sv */
// single-byte decode step: lead/continuation handling and surrogate join
module u8sj_decode
	import u8sj_pkg::*;
(
	input  u8sj_state_t  state,
	input  logic [7:0]   data_byte,
	input  logic         end_of_text,
	output u8sj_state_t  state_next,
	output u8sj_result_t result
);

	logic            done;
	logic            emit;
	logic            truncated;
	logic [CP_W-1:0] cp;
	logic [CP_W-1:0] res;
	logic [CP_W-1:0] shifted;
	logic [CP_W-1:0] joined;
	u8sj_state_t     nxt;

	// merge the low six bits of a continuation byte
	assign shifted = {state.partial_value[CP_W-7:0], data_byte[5:0]};

	// supplementary code point from held high half and current low half
	assign joined = {1'b0, state.held_high, cp[9:0]} + SUPP_BASE;

	always_comb begin
		done      = 1'b0;
		emit      = 1'b0;
		cp        = '0;
		res       = '0;
		truncated = 1'b0;
		nxt       = state;

		// byte decode
		if (state.bytes_left == 2'd0) begin
			if (data_byte[7] == 1'b0) begin
				cp   = CP_W'(data_byte);
				done = 1'b1;
			end else if (data_byte[7:5] == LEAD2_TAG) begin
				nxt.partial_value = CP_W'(data_byte[4:0]);
				nxt.bytes_left    = 2'd1;
			end else if (data_byte[7:4] == LEAD3_TAG) begin
				nxt.partial_value = CP_W'(data_byte[3:0]);
				nxt.bytes_left    = 2'd2;
			end else if (data_byte[7:3] == LEAD4_TAG) begin
				nxt.partial_value = CP_W'(data_byte[2:0]);
				nxt.bytes_left    = 2'd3;
			end else begin
				cp   = CP_INVALID;
				done = 1'b1;
			end
		end else begin
			nxt.bytes_left = state.bytes_left - 2'd1;
			if (state.bytes_left == 2'd1) begin
				cp                = shifted;
				nxt.partial_value = '0;
				done              = 1'b1;
			end else begin
				nxt.partial_value = shifted;
			end
		end

		// surrogate pairing on a finished code point
		if (done) begin
			if (state.surr_pending) begin
				if (cp >= LOW_SURR_LO && cp <= LOW_SURR_HI) begin
					res = joined;
				end else begin
					res = CP_INVALID;
				end
				nxt.surr_pending = 1'b0;
				nxt.held_high    = '0;
				emit             = 1'b1;
			end else if (cp >= HIGH_SURR_LO && cp <= HIGH_SURR_HI) begin
				nxt.held_high    = cp[9:0];
				nxt.surr_pending = 1'b1;
			end else begin
				res  = cp;
				emit = 1'b1;
			end
		end

		// end of text always yields one result and clears the state
		if (end_of_text) begin
			truncated = (nxt.bytes_left != 2'd0) || nxt.surr_pending;
			nxt       = '0;
		end

		state_next        = nxt;
		result.emit       = emit || end_of_text;
		result.code_point = truncated ? '0 : res;
		result.status     = truncated;
		result.last       = end_of_text;
	end

endmodule

/* rtl/utf8_decoder_surrogate_join_top.sv */
// top level of the utf8 / cesu-8 decoder with surrogate pair joining
// Takes one byte per cycle when not stalled (tlast marks the last byte of a
// text) and gives at most one code point per byte. Throughput is one byte per
// clock while s_tready is high. A byte is loaded into the input register at
// its transfer and decoded there against the running state. Its code point is
// loaded into the output register when the input stage advances, which sets
// output valid; the output transfer follows once m_tready is high.
// The output register decouples the two sides: input keeps flowing while a
// result waits, as long as the byte in the input register causes no result or
// the output register drains. tuser on the output is the truncated status, set
// when a text ends inside a sequence or with a high surrogate held (code point 0).
module utf8_decoder_surrogate_join_top
	import u8sj_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// slave side
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [TDATA_IN_W-1:0]  s_tdata,   // [7:0] data_byte
	input  logic                   s_tlast,   // end_of_text
	// master side
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [TDATA_OUT_W-1:0] m_tdata,   // [20:0] code_point, [23:21] zero
	output logic                   m_tuser,   // [0] status
	output logic                   m_tlast    // last
);

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         eot_s1;
	logic         adv;
	logic         out_valid_q;
	logic [CP_W-1:0] cp_q;
	logic         status_q;
	logic         last_q;
	u8sj_state_t  state_q;
	u8sj_state_t  state_next;
	u8sj_result_t result;

	// decode of the byte in the input register
	u8sj_decode u_decode (
		.state       (state_q),
		.data_byte   (byte_s1),
		.end_of_text (eot_s1),
		.state_next  (state_next),
		.result      (result)
	);

	// the input stage moves on unless its result finds the output register blocked
	assign adv      = valid_s1 && (!result.emit || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= '0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv) begin
				state_q <= state_next;
			end
			if (adv && result.emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// input payload register
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata[7:0];
			eot_s1  <= s_tlast;
		end
	end

	// output payload register
	always_ff @(posedge clk) begin
		if (adv && result.emit) begin
			cp_q     <= result.code_point;
			status_q <= result.status;
			last_q   <= result.last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(TDATA_OUT_W-CP_W){1'b0}}, cp_q};
	assign m_tuser  = status_q;
	assign m_tlast  = last_q;

endmodule

/* rtl/u8sj_checker.sv */
// port-level checker for the utf8 decoder and its bind to the top level
`include "utf8_decoder_surrogate_join_top_assert.svh"

module u8sj_checker
	import u8sj_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [TDATA_OUT_W-1:0] m_tdata,
	input logic                   m_tuser,
	input logic                   m_tlast
);

	// a truncated report carries code point zero
	`U8SJ_ASSERT_IMPL(a_trunc_zero, m_tvalid && m_tuser, m_tdata == '0)

	// a truncated report only closes a text
	`U8SJ_ASSERT_IMPL(a_trunc_last, m_tvalid && m_tuser, m_tlast)

	// code points never use the padding bits
	`U8SJ_ASSERT_IMPL(a_pad_zero, m_tvalid, m_tdata[TDATA_OUT_W-1:CP_W] == '0)

	// a stalled output transfer holds its payload
	`U8SJ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

endmodule

bind utf8_decoder_surrogate_join_top u8sj_checker u_u8sj_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
